/* hdl/bba_pkg.sv */
// Shared types, constants and helper functions for the binary buddy allocator.
// Depends on nothing; used by bba_tree_ram and binary_buddy_allocator.
package bba_pkg;

  localparam int TOTAL_UNITS = 1024;
  localparam int MIN_BLOCK   = 4;
  localparam int LEAVES      = TOTAL_UNITS / MIN_BLOCK;
  localparam int NODES       = 2 * LEAVES - 1;
  localparam int TOP_ORDER   = $clog2(LEAVES) + 1;
  localparam int LOG_MIN     = $clog2(MIN_BLOCK);

  localparam int IDX_W   = $clog2(NODES);
  localparam int ORD_W   = $clog2(TOP_ORDER + 1);
  localparam int REQ_W   = 11;
  localparam int START_W = 10;
  localparam int SIZE_W  = 11;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ORD_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } bba_mem_req_t;

  // Order of a wholly free node, from its depth in the heap.
  function automatic logic [ORD_W-1:0] node_order(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] n;
    int             lvl;
    n   = {1'b0, idx} + (IDX_W + 1)'(1);
    lvl = 0;
    for (int b = 0; b <= IDX_W; b++) begin
      if (n[b]) begin
        lvl = b;
      end
    end
    return ORD_W'(TOP_ORDER - lvl);
  endfunction

  // Smallest order whose block holds the request.
  function automatic logic [ORD_W-1:0] round_order(input logic [REQ_W-1:0] req);
    logic [ORD_W-1:0] n;
    n = ORD_W'(1);
    for (int k = 0; k < TOP_ORDER - 1; k++) begin
      if ((32'(MIN_BLOCK) << k) < 32'(req)) begin
        n = n + ORD_W'(1);
      end
    end
    return n;
  endfunction

  function automatic logic [SIZE_W-1:0] blk_size(input logic [ORD_W-1:0] ord);
    logic [31:0] s;
    s = 32'(MIN_BLOCK) << (ord - ORD_W'(1));
    return s[SIZE_W-1:0];
  endfunction

  function automatic logic [START_W-1:0] blk_start(input logic [IDX_W-1:0] idx,
                                                   input logic [ORD_W-1:0] ord);
    logic [31:0] first;
    logic [31:0] off;
    logic [31:0] s;
    first = (32'd1 << (TOP_ORDER - int'(ord))) - 32'd1;
    off   = 32'(idx) - first;
    s     = off << (LOG_MIN + int'(ord) - 1);
    return s[START_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] sibling(input logic [IDX_W-1:0] idx);
    return idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
  endfunction

endpackage

/* hdl/binary_buddy_allocator.sv */
// Binary buddy allocator: sequencer over a heap-ordered tree memory (bba_tree_ram).
// A zero or oversize allocation goes straight to the output register; an allocation walks
// down d levels below the root (d at most 8) and then back up, and a free walks up from
// its leaf; each level takes one read of the tree memory.
// Throughput: one request at a time; the next is taken the cycle after the result is loaded.
// Reset: asynchronous; a clearing pass then rewrites every node before use.
module binary_buddy_allocator import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_req_type_i,
  input  logic [REQ_W-1:0]   in_req_size_i,
  input  logic [START_W-1:0] in_free_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  out_status_o,
  output logic [START_W-1:0] out_block_start_o,
  output logic [SIZE_W-1:0]  out_block_size_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_DESC = 3'd3;
  localparam logic [2:0] S_FUP  = 3'd4;
  localparam logic [2:0] S_UP   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [ORD_W-1:0]   ord_q, ord_d;
  logic [ORD_W-1:0]   need_q, need_d;
  logic [ORD_W-1:0]   cur_q, cur_d;
  logic [START_W-1:0] fs_q, fs_d;
  logic               type_q, type_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [STAT_W-1:0]  res_status_q, res_status_d;
  logic [START_W-1:0] res_start_q, res_start_d;
  logic [SIZE_W-1:0]  res_size_q, res_size_d;
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [START_W-1:0] out_start_q;
  logic [SIZE_W-1:0]  out_size_q;

  bba_mem_req_t       mem_req;
  logic [ORD_W-1:0]   rdata;

  logic [IDX_W-1:0]   lchild, nidx, tgt_idx, par;
  logic [ORD_W-1:0]   nord, tgt_ord, pv;
  logic [START_W-1:0] tgt_start;
  logic [SIZE_W-1:0]  tgt_size;
  logic               fin_load;

  bba_tree_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

  assign lchild    = {idx_q[IDX_W-2:0], 1'b1};
  assign nidx      = (rdata >= need_q) ? lchild : lchild + IDX_W'(1);
  assign nord      = ord_q - ORD_W'(1);
  assign tgt_idx   = (state_q == S_DESC) ? nidx : idx_q;
  assign tgt_ord   = (state_q == S_DESC) ? nord : ord_q;
  assign tgt_start = blk_start(tgt_idx, tgt_ord);
  assign tgt_size  = blk_size(tgt_ord);
  assign par       = (idx_q - IDX_W'(1)) >> 1;
  assign fin_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (type_q == REQ_FREE && cur_q == ord_q && rdata == ord_q) begin
      pv = ord_q + ORD_W'(1);
    end else begin
      pv = (cur_q > rdata) ? cur_q : rdata;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    ord_d        = ord_q;
    need_d       = need_q;
    cur_d        = cur_q;
    fs_d         = fs_q;
    type_d       = type_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_size_d   = res_size_q;
    mem_req      = '0;

    unique case (state_q)
      S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
        mem_req.wdata = node_order(clr_q);
        clr_d         = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        res_status_d = ST_BAD;
        res_start_d  = '0;
        res_size_d   = '0;
        type_d       = in_req_type_i;
        fs_d         = in_free_start_i;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_ALLOC) begin
            if (in_req_size_i == '0 || 32'(in_req_size_i) > 32'(TOTAL_UNITS)) begin
              state_d = S_FIN;
            end else begin
              need_d        = round_order(in_req_size_i);
              idx_d         = '0;
              ord_d         = ORD_W'(TOP_ORDER);
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_d       = S_ROOT;
            end
          end else begin
            if (32'(in_free_start_i) >= 32'(TOTAL_UNITS)) begin
              state_d = S_FIN;
            end else begin
              idx_d         = IDX_W'(LEAVES - 1) + IDX_W'(in_free_start_i >> LOG_MIN);
              ord_d         = ORD_W'(1);
              mem_req.re    = 1'b1;
              mem_req.raddr = IDX_W'(LEAVES - 1) + IDX_W'(in_free_start_i >> LOG_MIN);
              state_d       = S_FUP;
            end
          end
        end
      end
      S_ROOT, S_DESC: begin
        if (state_q == S_ROOT && rdata < need_q) begin
          res_status_d = ST_NOSPACE;
          state_d      = S_FIN;
        end else if (state_q == S_ROOT && ord_q > need_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = lchild;
          state_d       = S_DESC;
        end else if (state_q == S_DESC && nord > need_q) begin
          idx_d         = nidx;
          ord_d         = nord;
          mem_req.re    = 1'b1;
          mem_req.raddr = {nidx[IDX_W-2:0], 1'b1};
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = tgt_idx;
          mem_req.wdata = '0;
          idx_d         = tgt_idx;
          ord_d         = tgt_ord;
          cur_d         = '0;
          res_status_d  = ST_DONE;
          res_start_d   = tgt_start;
          res_size_d    = tgt_size;
          if (tgt_idx == '0) begin
            state_d = S_FIN;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = sibling(tgt_idx);
            state_d       = S_UP;
          end
        end
      end
      S_FUP: begin
        if (rdata != '0) begin
          if (idx_q == '0) begin
            state_d = S_FIN;
          end else begin
            idx_d         = par;
            ord_d         = ord_q + ORD_W'(1);
            mem_req.re    = 1'b1;
            mem_req.raddr = par;
          end
        end else if (tgt_start != fs_q) begin
          state_d = S_FIN;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_q;
          mem_req.wdata = ord_q;
          cur_d         = ord_q;
          res_status_d  = ST_DONE;
          res_start_d   = tgt_start;
          res_size_d    = tgt_size;
          if (idx_q == '0) begin
            state_d = S_FIN;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = sibling(idx_q);
            state_d       = S_UP;
          end
        end
      end
      S_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = par;
        mem_req.wdata = pv;
        idx_d         = par;
        ord_d         = ord_q + ORD_W'(1);
        cur_d         = pv;
        if (par == '0) begin
          state_d = S_FIN;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = sibling(par);
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    ord_q        <= ord_d;
    need_q       <= need_d;
    cur_q        <= cur_d;
    fs_q         <= fs_d;
    type_q       <= type_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_size_q   <= res_size_d;
    if (fin_load) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_size_q   <= res_size_q;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_block_start_o = out_start_q;
  assign out_block_size_o  = out_size_q;

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_req.we)
    else $error("tree memory written while idle");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
    else $error("read and write of the same node in one cycle");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("result presented without a finished request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o == ST_DONE || out_status_o == ST_NOSPACE ||
                    out_status_o == ST_BAD)
    else $error("undefined status code");

  a_done_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o == ST_DONE |-> out_block_size_o != '0)
    else $error("successful transfer with zero block size");
`endif

endmodule

/* hdl/bba_tree_ram.sv */
// Single-write, single-read tree memory holding the largest free order of each node.
// Read data is registered; depends on bba_pkg.
module bba_tree_ram import bba_pkg::*; (
  input  logic             clk_i,
  input  bba_mem_req_t     req_i,
  output logic [ORD_W-1:0] rdata_o
);

  logic [ORD_W-1:0] mem_q [NODES];
  logic [ORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for binary_buddy_allocator: directed and random allocate and free
// traffic, each result checked against a predictor that mirrors the free-order tree.
// Depends on bba_pkg and the binary_buddy_allocator RTL only.
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1080;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } alloc_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_e;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               req_valid      = 1'b0;
  logic               req_stall;
  logic               req_type       = REQ_ALLOC;
  logic [REQ_W-1:0]   req_size       = '0;
  logic [START_W-1:0] req_free_start = '0;
  logic               rsp_valid;
  logic               rsp_stall      = 1'b0;
  logic [STAT_W-1:0]  rsp_status;
  logic [START_W-1:0] rsp_start;
  logic [SIZE_W-1:0]  rsp_size;

  logic [ORD_W-1:0]   tree_order [NODES];
  alloc_result_t      awaited_outcomes [$];
  logic [START_W-1:0] held_blocks [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 burst_left  = 0;

  stall_mode_e        stall_mode    = STALL_NONE;
  int                 stall_phase   = 0;
  logic [7:0]         stall_pattern = '0;

  binary_buddy_allocator u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (req_valid),
    .in_stall_o        (req_stall),
    .in_req_type_i     (req_type),
    .in_req_size_i     (req_size),
    .in_free_start_i   (req_free_start),
    .out_valid_o       (rsp_valid),
    .out_stall_i       (rsp_stall),
    .out_status_o      (rsp_status),
    .out_block_start_o (rsp_start),
    .out_block_size_o  (rsp_size)
  );

  always #5 clk = ~clk;

  function automatic int level_base(input int ord);
    return (1 << (TOP_ORDER - ord)) - 1;
  endfunction

  // Updates the tree copy for one request and returns the result the block should give.
  function automatic alloc_result_t apply_request(input logic rtype,
                                                  input logic [REQ_W-1:0] rsize,
                                                  input logic [START_W-1:0] fstart);
    alloc_result_t res;
    int need;
    int node;
    int ord;
    int bsize;
    int bstart;
    int lhs;
    int rhs;
    res = '{ST_BAD, '0, '0};
    if (rtype == REQ_ALLOC) begin
      if (rsize == 0 || int'(rsize) > TOTAL_UNITS) return res;
      need = 1;
      while ((MIN_BLOCK << (need - 1)) < int'(rsize)) need++;
      if (int'(tree_order[0]) < need) begin
        res.status = ST_NOSPACE;
        return res;
      end
      node = 0;
      ord  = TOP_ORDER;
      while (ord > need) begin
        node = (int'(tree_order[2 * node + 1]) >= need) ? 2 * node + 1 : 2 * node + 2;
        ord--;
      end
      tree_order[node] = '0;
      bsize  = MIN_BLOCK << (ord - 1);
      bstart = (node - level_base(ord)) * bsize;
      while (node > 0) begin
        node = (node - 1) / 2;
        lhs  = int'(tree_order[2 * node + 1]);
        rhs  = int'(tree_order[2 * node + 2]);
        tree_order[node] = ORD_W'(lhs > rhs ? lhs : rhs);
      end
    end else begin
      if (int'(fstart) >= TOTAL_UNITS) return res;
      node = LEAVES - 1 + int'(fstart) / MIN_BLOCK;
      ord  = 1;
      while (tree_order[node] != 0) begin
        if (node == 0) return res;
        node = (node - 1) / 2;
        ord++;
      end
      bsize  = MIN_BLOCK << (ord - 1);
      bstart = (node - level_base(ord)) * bsize;
      if (bstart != int'(fstart)) return res;
      tree_order[node] = ORD_W'(ord);
      while (node > 0) begin
        node = (node - 1) / 2;
        lhs  = int'(tree_order[2 * node + 1]);
        rhs  = int'(tree_order[2 * node + 2]);
        if (lhs == ord && rhs == ord) begin
          tree_order[node] = ORD_W'(ord + 1);
        end else begin
          tree_order[node] = ORD_W'(lhs > rhs ? lhs : rhs);
        end
        ord++;
      end
    end
    res.status = ST_DONE;
    res.start  = START_W'(bstart);
    res.size   = SIZE_W'(bsize);
    return res;
  endfunction

  // Presents one request, waits for its transfer, records the expected result and then
  // either carries straight on or leaves a gap at the end of a burst.
  task automatic transfer_request(input logic rtype, input logic [REQ_W-1:0] rsize,
                                  input logic [START_W-1:0] fstart);
    alloc_result_t res;
    req_valid      <= 1'b1;
    req_type       <= rtype;
    req_size       <= rsize;
    req_free_start <= fstart;
    do @(posedge clk); while (req_stall);
    res = apply_request(rtype, rsize, fstart);
    awaited_outcomes.push_back(res);
    if (res.status == ST_DONE) begin
      if (rtype == REQ_ALLOC) begin
        held_blocks.push_back(res.start);
      end else begin
        for (int k = 0; k < held_blocks.size(); k++) begin
          if (held_blocks[k] == res.start) begin
            held_blocks.delete(k);
            break;
          end
        end
      end
    end
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_bad_requests();
    transfer_request(REQ_ALLOC, '0, START_W'($urandom_range(0, 1023)));
    transfer_request(REQ_ALLOC, REQ_W'(TOTAL_UNITS + 1), START_W'($urandom_range(0, 1023)));
    transfer_request(REQ_ALLOC, '1, '1);
    transfer_request(REQ_FREE, '1, '1);
    transfer_request(REQ_FREE, '0, '0);
  endtask

  task automatic test_size_rounding();
    transfer_request(REQ_ALLOC, 11'd1, START_W'($urandom_range(0, 1023)));
    transfer_request(REQ_ALLOC, 11'd5, START_W'($urandom_range(0, 1023)));
    transfer_request(REQ_ALLOC, 11'd9, START_W'($urandom_range(0, 1023)));
    transfer_request(REQ_ALLOC, 11'd100, START_W'($urandom_range(0, 1023)));
    transfer_request(REQ_ALLOC, 11'd300, START_W'($urandom_range(0, 1023)));
    // A start inside an allocated block is not a block start.
    transfer_request(REQ_FREE, REQ_W'($urandom_range(0, 2047)),
                     START_W'(held_blocks[2] + MIN_BLOCK));
    while (held_blocks.size() != 0) begin
      transfer_request(REQ_FREE, REQ_W'($urandom_range(0, 2047)), held_blocks[0]);
    end
  endtask

  task automatic test_exhaustion();
    transfer_request(REQ_ALLOC, REQ_W'(TOTAL_UNITS), '1);
    transfer_request(REQ_ALLOC, 11'd1, '0);
    transfer_request(REQ_FREE, '1, '0);
    transfer_request(REQ_ALLOC, REQ_W'(TOTAL_UNITS / 2), '0);
    transfer_request(REQ_ALLOC, REQ_W'(TOTAL_UNITS), '0);
    transfer_request(REQ_ALLOC, REQ_W'(TOTAL_UNITS / 2), '0);
    transfer_request(REQ_ALLOC, REQ_W'(MIN_BLOCK), '0);
    transfer_request(REQ_FREE, '0, START_W'(TOTAL_UNITS / 2));
    transfer_request(REQ_FREE, '0, '0);
  endtask

  // Mostly balanced allocate and free traffic, with phases that push the region towards
  // full, plus a share of malformed sizes and frees of starts that are not held.
  task automatic test_random_traffic();
    int  pick;
    int  sel;
    bit  filling;
    logic [REQ_W-1:0] rsize;
    filling = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) filling = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        rsize = $urandom_range(0, 1) ? '0 : REQ_W'($urandom_range(TOTAL_UNITS + 1, 2047));
        transfer_request(REQ_ALLOC, rsize, START_W'($urandom_range(0, 1023)));
      end else if (pick < 8) begin
        transfer_request(REQ_FREE, REQ_W'($urandom_range(0, 2047)),
                         START_W'($urandom_range(0, 1023)));
      end else if (pick < 11 && held_blocks.size() != 0) begin
        transfer_request(REQ_FREE, REQ_W'($urandom_range(0, 2047)),
                         START_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]
                                  + MIN_BLOCK * $urandom_range(1, 3)));
      end else if (held_blocks.size() != 0 && pick < (filling ? 30 : 55)) begin
        transfer_request(REQ_FREE, REQ_W'($urandom_range(0, 2047)),
                         held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          rsize = REQ_W'($urandom_range(1, 32));
        end else if (sel < 96) begin
          rsize = REQ_W'($urandom_range(33, 256));
        end else begin
          rsize = REQ_W'($urandom_range(257, TOTAL_UNITS));
        end
        transfer_request(REQ_ALLOC, rsize, START_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode    = stall_mode_e'($urandom_range(0, 3));
      stall_phase   = $urandom_range(40, 250);
      stall_pattern = 8'($urandom);
      stall_pattern[$urandom_range(0, 7)] = 1'b0;
    end
    stall_phase--;
    case (stall_mode)
      STALL_NONE: begin
        rsp_stall <= 1'b0;
      end
      STALL_LIGHT: begin
        rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        rsp_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        rsp_stall <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
    endcase
  end

  always @(posedge clk) begin : check_results
    alloc_result_t exp;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: status %0d, block_start %0d, block_size %0d",
               rsp_status, rsp_start, rsp_size);
        error_count++;
      end else begin
        exp = awaited_outcomes.pop_front();
        if (rsp_status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, rsp_status);
          error_count++;
        end
        if (rsp_start !== exp.start) begin
          $error("block_start: expected %0d, actual %0d", exp.start, rsp_start);
          error_count++;
        end
        if (rsp_size !== exp.size) begin
          $error("block_size: expected %0d, actual %0d", exp.size, rsp_size);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int depth;
    for (int n = 0; n < NODES; n++) begin
      depth = 0;
      for (int k = n + 1; k > 1; k = k >> 1) depth++;
      tree_order[n] = ORD_W'(TOP_ORDER - depth);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_requests();
    test_size_rounding();
    test_exhaustion();
    test_random_traffic();
    if (req_valid) req_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
